// ===== hw/rtl/lpti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpti_pkg;

  // Field widths
  localparam int ANGLE_TURN_BITS = 16;
  localparam int COORD_BITS      = 24;
  localparam int PERIOD_W        = 30;
  localparam int SEC_W           = 32;
  localparam int NSEC_W          = 30;
  localparam int REL_W           = 33;
  localparam int ABS_W           = 63;
  localparam int IN_DATA_W       = 160;
  localparam int OUT_DATA_W      = 96;
  localparam int CFG_ADDR_W      = 2;

  // Internal widths
  localparam int CORDIC_STEPS = 30;
  localparam int AW           = ANGLE_TURN_BITS + 4;   // angle, signed
  localparam int CW           = COORD_BITS + 19;       // CORDIC x/y, signed
  localparam int ZW           = 34;                    // CORDIC z, 2^32 per turn
  localparam int DW           = AW - 1;                // divisor, unsigned
  localparam int MW           = PERIOD_W + AW - 1;     // dividend magnitude
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);
  localparam int CNT_W        = $clog2(MW);
  localparam int ROUND_SH     = 32 - ANGLE_TURN_BITS;

  // Angle constants in turn units
  localparam logic signed [AW-1:0] TURN    = AW'(64'd1 << ANGLE_TURN_BITS);
  localparam logic signed [AW-1:0] HALF    = AW'(64'd1 << (ANGLE_TURN_BITS - 1));
  localparam logic signed [AW-1:0] QUARTER = AW'(64'd1 << (ANGLE_TURN_BITS - 2));
  localparam logic signed [AW-1:0] THREE_Q = HALF + QUARTER;
  localparam logic signed [AW-1:0] THREE_H = TURN + HALF;

  localparam logic signed [ZW-1:0] Z_QTR     = ZW'(64'd1 << 30);
  localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(64'd1 << (31 - ANGLE_TURN_BITS));

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100000000);
  localparam logic [NSEC_W-1:0]   NS_PER_SEC   = NSEC_W'(1000000000);
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_ADDR = '0;

  // atan(2^-i), 2^32 units per turn, truncated
  function automatic logic [31:0] atan_lut(input logic [CIDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic              load_in;
    logic              cord_init;
    logic              cord_sel;     // 0: first point, 1: last point
    logic              cord_step;
    logic [CIDX_W-1:0] cord_idx;
    logic              save_start;
    logic              save_end;
    logic              hdr_commit;
    logic              unwrap;
    logic              mul;
    logic              div_init;
    logic              div_step;
    logic              out_load;
  } lpti_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic              is_point;
    logic              out_busy;
    logic signed [AW-1:0] span;
  } lpti_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lidar_point_timestamp_interp_core.sv =====
// Lidar point timestamp interpolator.
// Input stream: in_tuser selects the item kind (0 scan header, 1 point).
// A header carries the first and last point of a scan and its start time;
// it yields no result and sets the scan's start and end angles and start time.
// A point yields one result: time relative to scan start, absolute time
// floored at zero, and the half-passed flag.
// A point raises out_tvalid in the same cycle that in_tready returns. A header
// frees the input after both CORDIC passes and the scan state commit.
// Two 30-step CORDIC passes set the header time; for a point the 30-step
// CORDIC and the 49-bit one-bit-a-cycle divider set it. One item is worked
// on at a time; in_tready is high only between items.
// A finished result waits in the output register while the next item is
// accepted; a point whose result is ready holds until out_tready frees it.
// The APB port holds scan_period_ns at address 0; pready is always high.
// Reset (rst_n low, synchronous) restores a period of 100 ms, start angle 0,
// end angle one turn, the half-passed flag clear and scan start time zero.
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_timestamp_interp_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // point_x, point_y, last_x, last_y, start_sec, start_nsec, 2 pad bits
  input  wire logic [lpti_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // relative_ns, absolute_ns
  output logic [lpti_pkg::OUT_DATA_W-1:0]         out_tdata,
  // past_half
  output logic                                    out_tuser,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [lpti_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);
  import lpti_pkg::*;

  lpti_cmd_t           cmd;
  lpti_sts_t           sts;
  logic                cfg_we;
  logic [PERIOD_W-1:0] period;

  // Register access
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_PERIOD_ADDR) ? {{(32-PERIOD_W){1'b0}}, period} : '0;

  lpti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_pwdata[PERIOD_W-1:0]),
    .period     (period),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // Between items the scan span stays within half a turn to three half-turns
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (sts.span >= HALF) && (sts.span <= THREE_H))
    else $error("scan span out of range");

  // One item at a time: in_tready is low right after an accepted request
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  // Never overwrite a result that the receiver has not taken
  a_noovr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_tvalid && !out_tready))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lpti_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpti_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire lpti_pkg::lpti_sts_t sts,
  output lpti_pkg::lpti_cmd_t     cmd
);
  import lpti_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CINIT  = 4'd1;
  localparam logic [3:0] S_CITER  = 4'd2;
  localparam logic [3:0] S_CDONE  = 4'd3;
  localparam logic [3:0] S_HDR    = 4'd4;
  localparam logic [3:0] S_UNWRAP = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DINIT  = 4'd7;
  localparam logic [3:0] S_DITER  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pass_r, pass_nxt;

  // Sequence the CORDIC, header, multiply and divide steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.cord_sel = pass_r;
    cmd.cord_idx = cnt_r[CIDX_W-1:0];
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          pass_nxt    = 1'b0;
          state_nxt   = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_CITER;
      end
      S_CITER: begin
        cmd.cord_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_CDONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CDONE: begin
        if (sts.is_point) begin
          state_nxt = S_UNWRAP;
        end else if (!pass_r) begin
          cmd.save_start = 1'b1;
          pass_nxt       = 1'b1;
          state_nxt      = S_CINIT;
        end else begin
          cmd.save_end = 1'b1;
          state_nxt    = S_HDR;
        end
      end
      S_HDR: begin
        cmd.hdr_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_UNWRAP: begin
        cmd.unwrap = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DITER;
      end
      S_DITER: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(MW - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lpti_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpti_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lpti_pkg::lpti_cmd_t            cmd,
  output lpti_pkg::lpti_sts_t                 sts,
  input  wire logic                           in_tuser,
  input  wire logic [lpti_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [lpti_pkg::PERIOD_W-1:0]  cfg_wdata,
  output logic [lpti_pkg::PERIOD_W-1:0]       period,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lpti_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import lpti_pkg::*;

  localparam logic signed [MW+1:0] REL_MAX = (MW+2)'(64'sd4294967295);
  localparam logic signed [MW+1:0] REL_MIN = (MW+2)'(-64'sd4294967296);

  // Request fields
  logic                         op_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, lx_r, ly_r;
  logic [SEC_W-1:0]             sec_r;
  logic [NSEC_W-1:0]            nsec_r;

  // Scan state
  logic [PERIOD_W-1:0]  period_r;
  logic signed [AW-1:0] start_r, end_r;
  logic                 half_r;
  logic [ABS_W-1:0]     sns_r;

  // Work registers
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic                 zero_r;
  logic signed [AW-1:0] theta_r;
  logic signed [MW:0]   num_r;
  logic [DW-1:0]        den_r;
  logic [MW-1:0]        quo_r;
  logic [DW-1:0]        rem_r;
  logic                 neg_r;

  // Result register
  logic                  ov_r;
  logic [REL_W-1:0]      orel_r;
  logic [ABS_W-1:0]      oabs_r;
  logic                  ohalf_r;

  // CORDIC start vector
  logic signed [COORD_BITS-1:0] sx, sy;
  logic signed [CW-1:0]         xs, ys;
  always_comb begin
    sx = cmd.cord_sel ? lx_r : px_r;
    sy = cmd.cord_sel ? ly_r : py_r;
    xs = CW'(sx) <<< 16;
    ys = CW'(sy) <<< 16;
  end

  // CORDIC rotation step
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] dz;
  always_comb begin
    dx = cy_r >>> cmd.cord_idx;
    dy = cx_r >>> cmd.cord_idx;
    dz = $signed(ZW'(atan_lut(cmd.cord_idx)));
  end

  // Round the negated angle to turn units
  logic signed [ZW-1:0] zr, zs;
  logic signed [AW-1:0] ang;
  always_comb begin
    zr  = ROUND_ADD - cz_r;
    zs  = zr >>> ROUND_SH;
    ang = zero_r ? '0 : $signed(zs[AW-1:0]);
  end

  // Header end-angle fold
  logic signed [AW-1:0] span;
  assign span = end_r - start_r;

  // Unwrap the point angle
  logic signed [AW-1:0] th0, th1;
  logic                 half_nxt;
  always_comb begin
    half_nxt = half_r;
    if (!half_r) begin
      th0 = ang;
      if (th0 < start_r - QUARTER) begin
        th1 = th0 + TURN;
      end else if (th0 > start_r + THREE_Q) begin
        th1 = th0 - TURN;
      end else begin
        th1 = th0;
      end
      if (th1 - start_r > HALF) half_nxt = 1'b1;
    end else begin
      th0 = ang + TURN;
      if (th0 < end_r - THREE_Q) begin
        th1 = th0 + TURN;
      end else if (th0 > end_r + QUARTER) begin
        th1 = th0 - TURN;
      end else begin
        th1 = th0;
      end
    end
  end

  // Divider step: restoring, one quotient bit a cycle
  logic [DW:0] rsh;
  logic        ge;
  logic [DW:0] rsub;
  always_comb begin
    rsh  = {rem_r, quo_r[MW-1]};
    ge   = rsh >= {1'b0, den_r};
    rsub = rsh - {1'b0, den_r};
  end

  // Final rounding, saturation and absolute time
  logic [MW:0]            q;
  logic signed [MW+1:0]   relw;
  logic signed [REL_W-1:0] rel;
  logic signed [63:0]     absw;
  always_comb begin
    q    = {1'b0, quo_r} + (MW+1)'(neg_r && (rem_r != '0));
    relw = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (relw > REL_MAX) begin
      rel = REL_MAX[REL_W-1:0];
    end else if (relw < REL_MIN) begin
      rel = REL_MIN[REL_W-1:0];
    end else begin
      rel = relw[REL_W-1:0];
    end
    absw = $signed({1'b0, sns_r}) + 64'(rel);
  end

  // Control and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      start_r  <= '0;
      end_r    <= TURN;
      half_r   <= 1'b0;
      sns_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (cmd.save_start) start_r <= ang;
      if (cmd.save_end) end_r <= ang + TURN;
      if (cmd.hdr_commit) begin
        if (span > THREE_H) begin
          end_r <= end_r - TURN;
        end else if (span < HALF) begin
          end_r <= end_r + TURN;
        end
        half_r <= 1'b0;
        sns_r  <= ABS_W'(sec_r) * ABS_W'(NS_PER_SEC) + ABS_W'(nsec_r);
      end
      if (cmd.unwrap) half_r <= half_nxt;
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload path
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_tuser;
      px_r   <= $signed(in_tdata[23:0]);
      py_r   <= $signed(in_tdata[47:24]);
      lx_r   <= $signed(in_tdata[71:48]);
      ly_r   <= $signed(in_tdata[95:72]);
      sec_r  <= in_tdata[127:96];
      nsec_r <= in_tdata[157:128];
    end
    if (cmd.cord_init) begin
      zero_r <= (sx == '0) && (sy == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          cx_r <= ys;
          cy_r <= -xs;
          cz_r <= Z_QTR;
        end else begin
          cx_r <= -ys;
          cy_r <= xs;
          cz_r <= -Z_QTR;
        end
      end else begin
        cx_r <= xs;
        cy_r <= ys;
        cz_r <= '0;
      end
    end
    if (cmd.cord_step) begin
      if (!cy_r[CW-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + dz;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - dz;
      end
    end
    if (cmd.unwrap) theta_r <= th1;
    if (cmd.mul) begin
      num_r <= $signed({1'b0, period_r}) * (theta_r - start_r);
      den_r <= (span <= 0) ? DW'(1) : span[DW-1:0];
    end
    if (cmd.div_init) begin
      neg_r <= num_r[MW];
      quo_r <= num_r[MW] ? MW'(-num_r) : num_r[MW-1:0];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? rsub[DW-1:0] : rsh[DW-1:0];
      quo_r <= {quo_r[MW-2:0], ge};
    end
    if (cmd.out_load) begin
      orel_r  <= rel;
      oabs_r  <= absw[63] ? '0 : absw[ABS_W-1:0];
      ohalf_r <= half_r;
    end
  end

  assign sts.is_point = op_r;
  assign sts.out_busy = ov_r && !out_tready;
  assign sts.span     = span;
  assign period       = period_r;
  assign out_tvalid   = ov_r;
  assign out_tdata    = {oabs_r, orel_r};
  assign out_tuser    = ohalf_r;

endmodule
`default_nettype wire
